>>> src/oli_pkg.sv
// Shared constants for the ordered list block: field widths, command and status codes.
// Used by the channel interfaces, the entry memory and the top level.
package oli_pkg;

	localparam int DEPTH_DEFAULT = 16;

	localparam int FUNC_W   = 3;
	localparam int INDEX_W  = 5;
	localparam int DATA_W   = 32;
	localparam int COUNT_W  = 5;
	localparam int STATUS_W = 2;

	localparam logic [FUNC_W-1:0] FN_PUSH   = 3'd0;
	localparam logic [FUNC_W-1:0] FN_POP    = 3'd1;
	localparam logic [FUNC_W-1:0] FN_GET    = 3'd2;
	localparam logic [FUNC_W-1:0] FN_SET    = 3'd3;
	localparam logic [FUNC_W-1:0] FN_INSERT = 3'd4;
	localparam logic [FUNC_W-1:0] FN_ERASE  = 3'd5;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

endpackage

>>> src/oli_cmd_if.sv
// Command channel of the ordered list block: valid/ready plus func, index and value.
// Depends on oli_pkg for the field widths.
interface oli_cmd_if;
	import oli_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [FUNC_W-1:0]        func;
	logic [INDEX_W-1:0]       index;
	logic signed [DATA_W-1:0] value;

	modport source (output valid, func, index, value, input ready);
	modport sink   (input valid, func, index, value, output ready);
endinterface

>>> src/oli_rsp_if.sv
// Response channel of the ordered list block: valid/ready plus read value, count and status.
// Depends on oli_pkg for the field widths.
interface oli_rsp_if;
	import oli_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] read_value;
	logic [COUNT_W-1:0]       entry_count;
	logic [STATUS_W-1:0]      status;

	modport source (output valid, read_value, entry_count, status, input ready);
	modport sink   (input valid, read_value, entry_count, status, output ready);
endinterface

>>> src/oli_mem.sv
// Entry storage of the ordered list: one write port, one read port with registered data.
// Depends on oli_pkg for the data width.
module oli_mem #(
	parameter int DEPTH = oli_pkg::DEPTH_DEFAULT,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [oli_pkg::DATA_W-1:0] wdata,
	input  logic                      re,
	input  logic [AW-1:0]             raddr,
	output logic [oli_pkg::DATA_W-1:0] rdata
);
	import oli_pkg::*;

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Hold the last read word until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

>>> src/ordered_list_insert_erase.sv
// Ordered list of DEPTH signed 32-bit entries held in a single-port-read, single-port-write
// memory. Push, pop, set and every rejected command go from accept straight to the finish
// state; get does too, reading the memory in the accept cycle. Insert at index i into
// a list of n entries moves n-i entries one per cycle, then writes the new value; erase at
// index i moves n-1-i entries (none when the last entry is erased). The longest command is
// an insert at the front, bound by the memory moving one entry per cycle.
// A command is accepted only while the sequencer is idle; a finished result waits in an
// output register, so the next command may be taken while the previous result is unread.
// Depends on oli_pkg, oli_cmd_if, oli_rsp_if and oli_mem.
module ordered_list_insert_erase #(
	parameter int DEPTH = oli_pkg::DEPTH_DEFAULT
) (
	input logic        clk,
	input logic        arst_n,
	oli_cmd_if.sink    cmd,
	oli_rsp_if.source  rsp
);
	import oli_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = (CW > INDEX_W) ? CW : INDEX_W;
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
	localparam logic [CW-1:0] ONE_C    = CW'(1);
	localparam logic [AW-1:0] ONE_A    = AW'(1);
	localparam logic [PW-1:0] ONE_P    = PW'(1);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SHIFT = 4'b0010,
		S_LAST  = 4'b0100,
		S_FIN   = 4'b1000
	} state_t;

	state_t              state_q, state_d;
	logic [CW-1:0]       count_q, count_d;
	logic [AW-1:0]       ptr_q, ptr_d;
	logic [AW-1:0]       pos_q, pos_d;
	logic                ins_q, ins_d;
	logic                get_q, get_d;
	logic [DATA_W-1:0]   val_q, val_d;
	logic [STATUS_W-1:0] st_q, st_d;

	logic                out_valid_q;
	logic [DATA_W-1:0]   rd_val_q;
	logic [COUNT_W-1:0]  cnt_out_q;
	logic [STATUS_W-1:0] st_out_q;

	logic                mem_we, mem_re;
	logic [AW-1:0]       mem_waddr, mem_raddr;
	logic [DATA_W-1:0]   mem_wdata, mem_rdata;

	logic                acc, out_load;
	logic [PW-1:0]       pos_w, cnt_w;
	logic                in_range, ins_range, full, empty;
	logic [AW-1:0]       pos_a, cnt_a, last_a;

	assign cmd.ready = (state_q == S_IDLE);
	assign acc       = cmd.valid && cmd.ready;
	assign out_load  = (state_q == S_FIN) && (!out_valid_q || rsp.ready);

	assign pos_w     = PW'(cmd.index);
	assign cnt_w     = PW'(count_q);
	assign in_range  = pos_w < cnt_w;
	assign ins_range = pos_w <= cnt_w;
	assign full      = (count_q == FULL_CNT);
	assign empty     = (count_q == '0);
	assign pos_a     = AW'(cmd.index);
	assign cnt_a     = AW'(count_q);
	assign last_a    = AW'(count_q - ONE_C);

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		ptr_d     = ptr_q;
		pos_d     = pos_q;
		ins_d     = ins_q;
		get_d     = get_q;
		val_d     = val_q;
		st_d      = st_q;
		mem_we    = 1'b0;
		mem_waddr = pos_q;
		mem_wdata = val_q;
		mem_re    = 1'b0;
		mem_raddr = ptr_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					st_d    = ST_OK;
					get_d   = 1'b0;
					val_d   = cmd.value;
					pos_d   = pos_a;
					state_d = S_FIN;
					case (cmd.func)
						FN_PUSH: begin
							if (full) begin
								st_d = ST_FULL;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = cnt_a;
								mem_wdata = cmd.value;
								count_d   = count_q + ONE_C;
							end
						end
						FN_POP: begin
							if (empty) begin
								st_d = ST_EMPTY;
							end else begin
								count_d = count_q - ONE_C;
							end
						end
						FN_GET: begin
							if (!in_range) begin
								st_d = ST_RANGE;
							end else begin
								mem_re    = 1'b1;
								mem_raddr = pos_a;
								get_d     = 1'b1;
							end
						end
						FN_SET: begin
							if (!in_range) begin
								st_d = ST_RANGE;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = pos_a;
								mem_wdata = cmd.value;
							end
						end
						FN_INSERT: begin
							if (!ins_range) begin
								st_d = ST_RANGE;
							end else if (full) begin
								st_d = ST_FULL;
							end else if (pos_w == cnt_w) begin
								mem_we    = 1'b1;
								mem_waddr = pos_a;
								mem_wdata = cmd.value;
								count_d   = count_q + ONE_C;
							end else begin
								// Move entries up from the top end, one a cycle.
								mem_re    = 1'b1;
								mem_raddr = last_a;
								ptr_d     = last_a;
								ins_d     = 1'b1;
								state_d   = S_SHIFT;
							end
						end
						FN_ERASE: begin
							if (!in_range) begin
								st_d = ST_RANGE;
							end else if ((pos_w + ONE_P) == cnt_w) begin
								count_d = count_q - ONE_C;
							end else begin
								// Move entries down from just above the index.
								mem_re    = 1'b1;
								mem_raddr = pos_a + ONE_A;
								ptr_d     = pos_a + ONE_A;
								ins_d     = 1'b0;
								state_d   = S_SHIFT;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_SHIFT: begin
				mem_we    = 1'b1;
				mem_wdata = mem_rdata;
				if (ins_q) begin
					mem_waddr = ptr_q + ONE_A;
					if (ptr_q == pos_q) begin
						state_d = S_LAST;
					end else begin
						mem_re    = 1'b1;
						mem_raddr = ptr_q - ONE_A;
						ptr_d     = ptr_q - ONE_A;
					end
				end else begin
					mem_waddr = ptr_q - ONE_A;
					if (ptr_q == last_a) begin
						count_d = count_q - ONE_C;
						state_d = S_FIN;
					end else begin
						mem_re    = 1'b1;
						mem_raddr = ptr_q + ONE_A;
						ptr_d     = ptr_q + ONE_A;
					end
				end
			end
			S_LAST: begin
				mem_we    = 1'b1;
				mem_waddr = pos_q;
				mem_wdata = val_q;
				count_d   = count_q + ONE_C;
				state_d   = S_FIN;
			end
			S_FIN: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		ptr_q <= ptr_d;
		pos_q <= pos_d;
		ins_q <= ins_d;
		get_q <= get_d;
		val_q <= val_d;
		st_q  <= st_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rd_val_q  <= get_q ? mem_rdata : '0;
			cnt_out_q <= COUNT_W'(count_q);
			st_out_q  <= st_q;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.read_value  = rd_val_q;
	assign rsp.entry_count = cnt_out_q;
	assign rsp.status      = st_out_q;

	oli_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("entry count exceeds capacity");

	a_shift_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT) |-> (CW'(ptr_q) < count_q))
		else $error("shift pointer outside the live entries");

	a_write_addr: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (CW'(mem_waddr) < FULL_CNT))
		else $error("memory write beyond capacity");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_FIN) && out_valid_q && !rsp.ready) |=> (state_q == S_FIN))
		else $error("finished item left before its result was stored");
`endif
endmodule

>>> tb/tb_top.sv
// Self-checking testbench for ordered_list_insert_erase: drives list commands and checks results.
// Holds a shadow list that predicts every result, plus random stalls on both channels.
// Depends on oli_pkg, oli_cmd_if, oli_rsp_if and the block itself.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import oli_pkg::*;

	localparam int DEPTH        = 16;
	localparam int HOLD_CYCLES  = 200;
	localparam int IDLE_LIMIT   = 3000;
	localparam int TAIL_CYCLES  = 40;
	localparam int RANDOM_ITEMS = 525;

	localparam logic [FUNC_W-1:0] FN_SPARE_6 = 3'd6;
	localparam logic [FUNC_W-1:0] FN_SPARE_7 = 3'd7;

	localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

	typedef struct {
		logic signed [DATA_W-1:0] read_value;
		logic [COUNT_W-1:0]       entry_count;
		logic [STATUS_W-1:0]      status;
	} list_rsp_t;

	// Shadow copy of the list; predicts one result per accepted command.
	class list_checker;
		logic signed [DATA_W-1:0] shadow_entries [DEPTH];
		int unsigned              shadow_count;
		list_rsp_t                expected_rsp [$];
		int unsigned              mismatches;

		function new();
			shadow_count = 0;
			mismatches   = 0;
		endfunction

		function void note_command(logic [FUNC_W-1:0] f, logic [INDEX_W-1:0] idx,
				logic signed [DATA_W-1:0] v);
			list_rsp_t   r;
			int unsigned pos;
			pos          = 32'(idx);
			r.read_value = '0;
			r.status     = ST_OK;
			case (f)
				FN_PUSH: begin
					if (shadow_count >= DEPTH) begin
						r.status = ST_FULL;
					end else begin
						shadow_entries[shadow_count] = v;
						shadow_count++;
					end
				end
				FN_POP: begin
					if (shadow_count == 0) r.status = ST_EMPTY;
					else shadow_count--;
				end
				FN_GET: begin
					if (pos >= shadow_count) r.status = ST_RANGE;
					else r.read_value = shadow_entries[pos];
				end
				FN_SET: begin
					if (pos >= shadow_count) r.status = ST_RANGE;
					else shadow_entries[pos] = v;
				end
				FN_INSERT: begin
					// index test first: a bad index into a full list reports range
					if (pos > shadow_count) begin
						r.status = ST_RANGE;
					end else if (shadow_count >= DEPTH) begin
						r.status = ST_FULL;
					end else begin
						for (int k = shadow_count; k > pos; k--)
							shadow_entries[k] = shadow_entries[k-1];
						shadow_entries[pos] = v;
						shadow_count++;
					end
				end
				FN_ERASE: begin
					if (pos >= shadow_count) begin
						r.status = ST_RANGE;
					end else begin
						for (int k = pos; k + 1 < shadow_count; k++)
							shadow_entries[k] = shadow_entries[k+1];
						shadow_count--;
					end
				end
				default: ;
			endcase
			r.entry_count = shadow_count[COUNT_W-1:0];
			expected_rsp.insert(expected_rsp.size(), r);
		endfunction

		function void check_response(logic signed [DATA_W-1:0] rd, logic [COUNT_W-1:0] cnt,
				logic [STATUS_W-1:0] st);
			list_rsp_t want;
			if (expected_rsp.size() == 0) begin
				$error("result with no command pending: read_value %0d entry_count %0d status %0d",
					rd, cnt, st);
				mismatches++;
			end else begin
				want = expected_rsp.pop_front();
				if (rd !== want.read_value) begin
					$error("read_value: expected %0d, got %0d", want.read_value, rd);
					mismatches++;
				end
				if (cnt !== want.entry_count) begin
					$error("entry_count: expected %0d, got %0d", want.entry_count, cnt);
					mismatches++;
				end
				if (st !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, st);
					mismatches++;
				end
			end
		endfunction

		function int unsigned pending();
			return expected_rsp.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	list_checker sb;
	bit          hold_rsp_req;
	bit          hold_active;
	bit          grow;
	int unsigned burst_left;
	int unsigned idle_cycles;

	oli_cmd_if cmd ();
	oli_rsp_if rsp ();

	ordered_list_insert_erase #(
		.DEPTH(DEPTH)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.rsp   (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Mostly short gaps, a few long ones, none while a burst is running.
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (burst_left != 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_command(input logic [FUNC_W-1:0] f, input logic [INDEX_W-1:0] idx,
			input logic signed [DATA_W-1:0] v);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			cmd.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd.valid <= 1'b1;
		cmd.func  <= f;
		cmd.index <= idx;
		cmd.value <= v;
		do @(posedge clk); while (!cmd.ready);
	endtask

	// Drop valid and hold until every predicted result has come back.
	task automatic wait_drained();
		cmd.valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	function automatic logic signed [DATA_W-1:0] pick_value();
		if ($urandom_range(0, 9) != 0) return $urandom;
		case ($urandom_range(0, 3))
			0: return VAL_MIN;
			1: return VAL_MAX;
			2: return '0;
			default: return '1;
		endcase
	endfunction

	// Mostly well-formed commands with indexes that fit the current count; a few out of range
	// and a little raw noise, spare codes included. Bias toward growing or shrinking the list.
	task automatic make_command(output logic [FUNC_W-1:0] f, output logic [INDEX_W-1:0] idx,
			output logic signed [DATA_W-1:0] v);
		int unsigned n;
		int unsigned r;
		n = sb.shadow_count;
		if (n >= DEPTH) grow = 1'b0;
		else if (n == 0) grow = 1'b1;
		else if ($urandom_range(0, 29) == 0) grow = ~grow;
		v = pick_value();
		if ($urandom_range(0, 99) < 4) begin
			f   = FUNC_W'($urandom_range(0, 7));
			idx = INDEX_W'($urandom_range(0, 31));
		end else begin
			r = $urandom_range(0, 99);
			if (grow) begin
				if (r < 25) f = FN_PUSH;
				else if (r < 50) f = FN_INSERT;
				else if (r < 62) f = FN_GET;
				else if (r < 74) f = FN_SET;
				else if (r < 87) f = FN_ERASE;
				else f = FN_POP;
			end else begin
				if (r < 10) f = FN_PUSH;
				else if (r < 20) f = FN_INSERT;
				else if (r < 35) f = FN_GET;
				else if (r < 50) f = FN_SET;
				else if (r < 75) f = FN_ERASE;
				else f = FN_POP;
			end
			if (f == FN_INSERT) begin
				if ($urandom_range(0, 9) != 0) idx = INDEX_W'($urandom_range(0, n));
				else idx = INDEX_W'($urandom_range(n + 1, 31));
			end else if (f == FN_GET || f == FN_SET || f == FN_ERASE) begin
				if (n > 0 && $urandom_range(0, 9) != 0) idx = INDEX_W'($urandom_range(0, n - 1));
				else idx = INDEX_W'($urandom_range(n, 31));
			end else begin
				idx = INDEX_W'($urandom_range(0, 31));
			end
		end
	endtask

	// Receiver: random ready pattern, plus one long hold on request.
	initial begin
		rsp.ready <= 1'b0;
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			if (hold_rsp_req) begin
				hold_active = 1'b1;
				rsp.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_active  = 1'b0;
				hold_rsp_req = 1'b0;
			end else begin
				case ($urandom_range(0, 19))
					0, 1, 2, 3, 4, 5, 6, 7, 8, 9: begin
						rsp.ready <= 1'b1;
						repeat ($urandom_range(1, 20)) @(posedge clk);
					end
					10, 11, 12, 13, 14, 15, 16: begin
						rsp.ready <= 1'b0;
						repeat ($urandom_range(1, 3)) @(posedge clk);
					end
					default: begin
						rsp.ready <= 1'b0;
						repeat ($urandom_range(10, 50)) @(posedge clk);
					end
				endcase
			end
		end
	end

	// Monitor and watchdog.
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (cmd.valid && cmd.ready) sb.note_command(cmd.func, cmd.index, cmd.value);
			if (rsp.valid && rsp.ready)
				sb.check_response(rsp.read_value, rsp.entry_count, rsp.status);
			if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
				$display("[ordered_list_insert_erase] ERROR");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		logic [FUNC_W-1:0]        f;
		logic [INDEX_W-1:0]       idx;
		logic signed [DATA_W-1:0] v;
		int unsigned              counted;
		bit                       hold_done;
		bit                       drain_done;

		sb           = new();
		hold_rsp_req = 1'b0;
		hold_active  = 1'b0;
		grow         = 1'b1;
		burst_left   = 0;
		idle_cycles  = 0;
		counted      = 0;
		hold_done    = 1'b0;
		drain_done   = 1'b0;
		cmd.valid <= 1'b0;
		cmd.func  <= FN_PUSH;
		cmd.index <= '0;
		cmd.value <= '0;
		arst_n    <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list corner cases
		send_command(FN_POP, 5'd0, '0);
		send_command(FN_ERASE, 5'd0, '0);
		send_command(FN_INSERT, 5'd1, 32'sd7);
		send_command(FN_INSERT, 5'd0, VAL_MIN);
		send_command(FN_PUSH, 5'd31, VAL_MAX);
		send_command(FN_INSERT, 5'd1, '1);
		send_command(FN_GET, 5'd1, '0);
		send_command(FN_SET, 5'd2, 32'sh5555_5555);
		send_command(FN_GET, 5'd31, '0);
		send_command(FN_SPARE_6, 5'd0, '1);
		// fill to capacity with inserts at the front, middle and back
		for (int k = 0; k < 13; k++)
			send_command(FN_INSERT, INDEX_W'((k * 5) % (k + 4)), $urandom);
		send_command(FN_PUSH, 5'd0, 32'sd1);
		send_command(FN_INSERT, 5'd16, 32'sd2);
		send_command(FN_INSERT, 5'd17, 32'sd3);
		send_command(FN_ERASE, 5'd0, '0);
		send_command(FN_SPARE_7, 5'd31, '0);

		while (counted < RANDOM_ITEMS) begin
			if (!hold_done && counted >= 150) begin
				// stall the result side long enough for the block to back up
				hold_done    = 1'b1;
				hold_rsp_req = 1'b1;
				cmd.valid <= 1'b0;
				do @(posedge clk); while (!hold_active);
				burst_left = 12;
			end else if (!drain_done && counted >= 350) begin
				drain_done = 1'b1;
				wait_drained();
			end else if (burst_left == 0 && $urandom_range(0, 39) == 0) begin
				burst_left = $urandom_range(10, 30);
			end
			make_command(f, idx, v);
			send_command(f, idx, v);
			if (f <= FN_ERASE) counted++;
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("[ordered_list_insert_erase] OK");
		end else begin
			$display("[ordered_list_insert_erase] ERROR");
		end
		$finish;
	end

endmodule

>>> files.f
src/oli_pkg.sv
src/oli_cmd_if.sv
src/oli_rsp_if.sv
src/oli_mem.sv
src/ordered_list_insert_erase.sv
tb/tb_top.sv
